### rtl/mpe_pkg.sv
`default_nettype none

package mpe_pkg;

    localparam int FORWARD_PRIMITIVES = 3;
    localparam logic [2:0] LAST_PRIMITIVE = 3'd5;
    localparam int SINE_DEPTH_DEFAULT = 1024;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Penalty factor of exactly one in Q4.8.
    localparam logic [11:0] PENALTY_ONE = 12'd256;

    localparam logic [1:0] REG_TURN_PENALTY = 2'd0;
    localparam logic [1:0] REG_REVERSE_PENALTY = 2'd1;
    localparam logic [1:0] REG_DIR_CHANGE_PENALTY = 2'd2;

    typedef struct packed {
        logic turn_hit;
        logic dir_hit;
        logic rev;
    } cost_ctl_t;

    typedef struct packed {
        logic       rev;
        logic [1:0] base;
    } pose_ctl_t;

    function automatic logic signed [17:0] fwd_offset(input logic [1:0] base);
        logic signed [17:0] r;
        begin
            r = (base == 2'd0) ? 18'sd46325 : 18'sd46218;
            return r;
        end
    endfunction

    function automatic logic signed [17:0] lat_offset(input logic [1:0] base);
        logic signed [17:0] r;
        begin
            case (base)
                2'd1: r = -18'sd2726;
                2'd2: r = 18'sd2726;
                default: r = 18'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [15:0] turn_angle(input logic [1:0] base);
        logic [15:0] r;
        begin
            case (base)
                2'd1: r = 16'd1229;
                2'd2: r = 16'd64307;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/mpe_sine_rom.sv
`default_nettype none

module mpe_sine_rom #(
    parameter int SINE_TABLE_DEPTH = mpe_pkg::SINE_DEPTH_DEFAULT,
    parameter int AW = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic [AW-1:0] addr_a,
    input  wire logic [AW-1:0] addr_b,
    output logic      [14:0]   data_a_reg,
    output logic      [14:0]   data_b_reg
);

    logic [14:0] rom [0:SINE_TABLE_DEPTH];

    // Each entry is a Q30 Taylor series of sin, rounded to Q15 and clamped.
    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
        localparam logic [63:0] A = (mpe_pkg::HALF_PI_Q30 * 64'(k)
                                    + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        localparam logic [63:0] A2 = (A * A) >> 30;
        localparam logic [63:0] T1 = ((A * A2) >> 30) / 6;
        localparam logic [63:0] T2 = ((T1 * A2) >> 30) / 20;
        localparam logic [63:0] T3 = ((T2 * A2) >> 30) / 42;
        localparam logic [63:0] T4 = ((T3 * A2) >> 30) / 72;
        localparam logic [63:0] T5 = ((T4 * A2) >> 30) / 110;
        localparam logic [63:0] T6 = ((T5 * A2) >> 30) / 156;
        localparam logic [63:0] SUM = A - T1 + T2 - T3 + T4 - T5 + T6;
        localparam logic [63:0] R = (SUM + 64'd16384) >> 15;
        localparam logic [63:0] V = (R > 64'd32767) ? 64'd32767 : R;
        assign rom[k] = V[14:0];
    end

    always_ff @(posedge clk)
    begin
        data_a_reg <= rom[addr_a];
        data_b_reg <= rom[addr_b];
    end

endmodule

`default_nettype wire

### rtl/mpe_pose.sv
`default_nettype none

module mpe_pose #(
    parameter int SINE_TABLE_DEPTH = mpe_pkg::SINE_DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic signed [31:0]  px,
    input  wire logic signed [31:0]  py,
    input  wire logic        [15:0]  heading,
    input  wire mpe_pkg::pose_ctl_t  ctl,
    output logic signed      [31:0]  x_reg,
    output logic signed      [31:0]  y_reg,
    output logic             [15:0]  heading_reg
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 14 + AW;

    logic [15:0]   cos_ang;
    logic [PW-1:0] sin_prod, cos_prod;
    logic [AW-1:0] sin_idx, cos_idx, sin_addr, cos_addr;
    logic [14:0]   sin_mag, cos_mag;
    logic [15:0]   nh_next;

    // Stage 1: table read and pass-along.
    logic                sin_neg_reg, cos_neg_reg;
    logic signed [17:0]  fo1_reg, lo1_reg;
    logic signed [31:0]  px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic [15:0]         nh1_reg, nh2_reg, nh3_reg;

    // Stage 2: products.
    logic signed [15:0]  s_val, c_val;
    logic signed [33:0]  fc_reg, ls_reg, fs_reg, lc_reg;

    // Stage 3: rounded displacement.
    logic signed [35:0]  dx_sum, dy_sum;
    logic signed [31:0]  ddx_reg, ddy_reg;

    assign cos_ang  = heading + 16'd16384;
    assign sin_prod = PW'(heading[13:0]) * PW'(SINE_TABLE_DEPTH);
    assign cos_prod = PW'(cos_ang[13:0]) * PW'(SINE_TABLE_DEPTH);
    assign sin_idx  = sin_prod[PW-1:14];
    assign cos_idx  = cos_prod[PW-1:14];
    assign sin_addr = heading[14] ? AW'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;
    assign cos_addr = cos_ang[14] ? AW'(SINE_TABLE_DEPTH) - cos_idx : cos_idx;
    assign nh_next  = ctl.rev ? heading - mpe_pkg::turn_angle(ctl.base)
                              : heading + mpe_pkg::turn_angle(ctl.base);

    mpe_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .AW(AW)
    ) u_rom (
        .clk(clk),
        .addr_a(sin_addr),
        .addr_b(cos_addr),
        .data_a_reg(sin_mag),
        .data_b_reg(cos_mag)
    );

    assign s_val = sin_neg_reg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign c_val = cos_neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

    // Rounding half up to Q16.16 is an arithmetic shift after the bias.
    assign dx_sum = 36'(fc_reg) - 36'(ls_reg) + 36'sd16384;
    assign dy_sum = 36'(fs_reg) + 36'(lc_reg) + 36'sd16384;

    always_ff @(posedge clk)
    begin
        sin_neg_reg <= heading[15];
        cos_neg_reg <= cos_ang[15];
        fo1_reg     <= ctl.rev ? -mpe_pkg::fwd_offset(ctl.base)
                               : mpe_pkg::fwd_offset(ctl.base);
        lo1_reg     <= mpe_pkg::lat_offset(ctl.base);
        px1_reg     <= px;
        py1_reg     <= py;
        nh1_reg     <= nh_next;

        fc_reg  <= fo1_reg * c_val;
        ls_reg  <= lo1_reg * s_val;
        fs_reg  <= fo1_reg * s_val;
        lc_reg  <= lo1_reg * c_val;
        px2_reg <= px1_reg;
        py2_reg <= py1_reg;
        nh2_reg <= nh1_reg;

        ddx_reg <= 32'(dx_sum >>> 15);
        ddy_reg <= 32'(dy_sum >>> 15);
        px3_reg <= px2_reg;
        py3_reg <= py2_reg;
        nh3_reg <= nh2_reg;

        x_reg       <= px3_reg + ddx_reg;
        y_reg       <= py3_reg + ddy_reg;
        heading_reg <= nh3_reg;
    end

endmodule

`default_nettype wire

### rtl/mpe_cost.sv
`default_nettype none

module mpe_cost (
    input  wire logic               clk,
    input  wire logic [15:0]        step_cost,
    input  wire logic [31:0]        parent_cost,
    input  wire mpe_pkg::cost_ctl_t ctl,
    input  wire logic [11:0]        turn_penalty,
    input  wire logic [11:0]        reverse_penalty,
    input  wire logic [11:0]        direction_change_penalty,
    output logic      [31:0]        cost_reg,
    output logic                    sat_reg
);

    // A penalty that does not apply is replaced by one, so the product always
    // carries 24 fraction bits and one rounding step covers every case.
    logic [27:0]        p1_reg;
    logic [39:0]        p2_reg;
    logic [51:0]        p3_reg;
    mpe_pkg::cost_ctl_t ctl1_reg, ctl2_reg;
    logic [31:0]        pc1_reg, pc2_reg, pc3_reg;
    logic [11:0]        f1, f2, f3;
    logic [51:0]        rounded;
    logic [32:0]        total;

    assign f1 = ctl.turn_hit ? turn_penalty : mpe_pkg::PENALTY_ONE;
    assign f2 = ctl1_reg.dir_hit ? direction_change_penalty : mpe_pkg::PENALTY_ONE;
    assign f3 = ctl2_reg.rev ? reverse_penalty : mpe_pkg::PENALTY_ONE;

    assign rounded = (p3_reg + 52'd8388608) >> 24;
    assign total   = 33'(pc3_reg) + 33'(rounded[28:0]);

    always_ff @(posedge clk)
    begin
        p1_reg   <= 28'(step_cost) * 28'(f1);
        ctl1_reg <= ctl;
        pc1_reg  <= parent_cost;

        p2_reg   <= 40'(p1_reg) * 40'(f2);
        ctl2_reg <= ctl1_reg;
        pc2_reg  <= pc1_reg;

        p3_reg   <= 52'(p2_reg) * 52'(f3);
        pc3_reg  <= pc2_reg;

        cost_reg <= total[32] ? 32'hFFFF_FFFF : total[31:0];
        sat_reg  <= total[32];
    end

endmodule

`default_nettype wire

### rtl/motion_primitive_expand.sv
// Throughput: one request per cycle; busy is always low and the pipeline never stalls.
// The pose side spends one stage each on the sine table read, the offset products, the
// rounding and the final add; the cost side spends three on the penalty products and one
// on the add. The receiver cannot stall: done is a single-cycle strobe.
// Reset clears the valid pipeline and sets the penalty registers to 269, 512 and 512.
`default_nettype none

module motion_primitive_expand #(
    parameter int SINE_TABLE_DEPTH = mpe_pkg::SINE_DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] parent_x,
    input  wire logic signed [31:0] parent_y,
    input  wire logic        [15:0] parent_heading,
    input  wire logic        [31:0] parent_cost,
    input  wire logic        [2:0]  parent_primitive,
    input  wire logic        [2:0]  primitive_req,
    input  wire logic        [15:0] step_cost,
    input  wire logic               wr_en,
    input  wire logic        [1:0]  wr_index,
    input  wire logic        [11:0] wr_data,
    output logic                    done,
    output logic signed      [31:0] succ_x,
    output logic signed      [31:0] succ_y,
    output logic             [15:0] succ_heading,
    output logic             [31:0] succ_cost,
    output logic                    cost_saturated
);

    logic [11:0] turn_penalty_reg, reverse_penalty_reg, dir_penalty_reg;
    logic [3:0]  valid_reg;
    logic [2:0]  pp, rq, base_full;
    logic        rev, prev_rev;
    mpe_pkg::cost_ctl_t cost_ctl;
    mpe_pkg::pose_ctl_t pose_ctl;

    assign busy = 1'b0;

    assign pp = (parent_primitive > mpe_pkg::LAST_PRIMITIVE) ? mpe_pkg::LAST_PRIMITIVE
                                                             : parent_primitive;
    assign rq = (primitive_req > mpe_pkg::LAST_PRIMITIVE) ? mpe_pkg::LAST_PRIMITIVE
                                                          : primitive_req;
    assign rev       = rq >= 3'(mpe_pkg::FORWARD_PRIMITIVES);
    assign prev_rev  = pp >= 3'(mpe_pkg::FORWARD_PRIMITIVES);
    assign base_full = rev ? rq - 3'(mpe_pkg::FORWARD_PRIMITIVES) : rq;

    assign cost_ctl.turn_hit = pp != rq;
    assign cost_ctl.dir_hit  = (pp != rq) && (rev != prev_rev);
    assign cost_ctl.rev      = rev;
    assign pose_ctl.rev      = rev;
    assign pose_ctl.base     = base_full[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_penalty_reg    <= 12'd269;
            reverse_penalty_reg <= 12'd512;
            dir_penalty_reg     <= 12'd512;
            valid_reg           <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], start};
            if (wr_en)
            begin
                case (wr_index)
                    mpe_pkg::REG_TURN_PENALTY:       turn_penalty_reg <= wr_data;
                    mpe_pkg::REG_REVERSE_PENALTY:    reverse_penalty_reg <= wr_data;
                    mpe_pkg::REG_DIR_CHANGE_PENALTY: dir_penalty_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    assign done = valid_reg[3];

    mpe_pose #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_pose (
        .clk(clk),
        .px(parent_x),
        .py(parent_y),
        .heading(parent_heading),
        .ctl(pose_ctl),
        .x_reg(succ_x),
        .y_reg(succ_y),
        .heading_reg(succ_heading)
    );

    mpe_cost u_cost (
        .clk(clk),
        .step_cost(step_cost),
        .parent_cost(parent_cost),
        .ctl(cost_ctl),
        .turn_penalty(turn_penalty_reg),
        .reverse_penalty(reverse_penalty_reg),
        .direction_change_penalty(dir_penalty_reg),
        .cost_reg(succ_cost),
        .sat_reg(cost_saturated)
    );

endmodule

`default_nettype wire
